// File: rtl/core/sss_pkg.sv
// Package for the semaphore sleep scheduler.
// Holds sizes, operation codes, FSM states and the sleep conversion constants.
`default_nettype none
package sss_pkg;
    localparam int NUM_PROCS_D  = 8;
    localparam int NUM_SEMS_D   = 4;
    localparam int WAIT_DEPTH_D = 8;
    localparam int TICK_HZ_D    = 100;
    localparam int BLOCK_MILLIS = 100000;
    localparam int MILLIS_SEC   = 1000;
    localparam int SLEEP_MAX    = 65535;
    localparam int COUNT_MAX    = 127;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_SCHED = 3'd1,
        OP_SLEEP = 3'd2,
        OP_P     = 3'd3,
        OP_V     = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_SCAN,
        ST_RELOAD,
        ST_QRD,
        ST_QSHIFT,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// File: rtl/core/sss_proc_mem.sv
// Process table memory: ticks, priority and sleep count per entry.
// One write port, one registered read port. Depends on sss_pkg.
`default_nettype none
module sss_proc_mem #(
    parameter int NUM_PROCS = sss_pkg::NUM_PROCS_D,
    localparam int AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);
    logic [31:0] r_mem [NUM_PROCS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/sss_queue_mem.sv
// Wait queue memory: one slot per semaphore and queue position.
// One write port, one registered read port. Depends on sss_pkg.
`default_nettype none
module sss_queue_mem #(
    parameter int DEPTH = sss_pkg::NUM_SEMS_D * sss_pkg::WAIT_DEPTH_D,
    parameter int DW    = 3,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/semaphore_sleep_scheduler.sv
// Top level of the semaphore sleep scheduler: control FSM, counts, valid bits.
// Uses sss_pkg, sss_proc_mem and sss_queue_mem.
//
// One command word is taken when i_start is high and o_busy low. One result
// word follows on o_done for a single cycle and cannot be held off, so it
// must be captured when it appears. A write, a sleep, a P that does not
// block, a V that wakes nobody or an undefined op passes through the read,
// execute and done states. o_done rises in the same cycle that o_busy falls.
// Schedule scans the process memory one entry a cycle. When ticks run out
// the table is reloaded and scanned again. A P that blocks runs the same
// scan. A V that wakes a process reads the queue head, clears its sleep count
// and shifts the remaining queue slots forward. The process table starts
// cleared through per-entry valid bits.
`default_nettype none
module semaphore_sleep_scheduler #(
    parameter int NUM_PROCS  = sss_pkg::NUM_PROCS_D,
    parameter int NUM_SEMS   = sss_pkg::NUM_SEMS_D,
    parameter int WAIT_DEPTH = sss_pkg::WAIT_DEPTH_D,
    parameter int TICK_HZ    = sss_pkg::TICK_HZ_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [2:0]        i_op,
    input  wire logic [2:0]        i_proc_id,
    input  wire logic [1:0]        i_sem_id,
    input  wire logic [7:0]        i_tick_budget,
    input  wire logic [7:0]        i_prio_level,
    input  wire logic [15:0]       i_sleep_count,
    input  wire logic [19:0]       i_sleep_millis,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    output logic                   o_done,
    output logic                   o_ready_found,
    output logic [2:0]             o_ready_proc,
    output logic                   o_blocked,
    output logic                   o_woke,
    output logic [2:0]             o_woken_proc,
    output logic signed [7:0]      o_sem_count_out,
    output logic                   o_queue_full
);
    localparam int PAW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int QD  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QAW = SW + QD;
    localparam int QDEPTH = NUM_SEMS * (2 ** QD);
    localparam int PCW = $clog2(NUM_PROCS + 1);
    localparam logic [15:0] BLOCK_TICKS =
        16'((sss_pkg::BLOCK_MILLIS * TICK_HZ / sss_pkg::MILLIS_SEC > sss_pkg::SLEEP_MAX)
            ? sss_pkg::SLEEP_MAX : sss_pkg::BLOCK_MILLIS * TICK_HZ / sss_pkg::MILLIS_SEC);
    // products at or above this saturate; below it they fit in 26 bits
    localparam logic [29:0] SAT_PROD =
        30'((sss_pkg::SLEEP_MAX + 1) * sss_pkg::MILLIS_SEC);
    // ceil(2^36 / 1000): exact quotient for any 26-bit dividend
    localparam logic [26:0] MS_RECIP =
        27'(((64'd1 << 36) + 64'(sss_pkg::MILLIS_SEC) - 64'd1) / 64'(sss_pkg::MILLIS_SEC));

    sss_pkg::t_state r_state, n_state;

    logic [2:0]  r_op;
    logic [2:0]  r_pid;
    logic [1:0]  r_sid;
    logic [7:0]  r_tick;
    logic [7:0]  r_prio;
    logic [15:0] r_slp;
    logic [15:0] r_conv;
    logic [29:0] r_prod;
    logic signed [7:0] r_cnt [NUM_SEMS];
    logic [NUM_PROCS-1:0] r_valid;
    logic [2:0]  r_cur;
    logic [PCW-1:0] r_idx;
    logic [7:0]  r_best;
    logic        r_found;
    logic        r_pass2;
    logic [QD:0] r_qi;
    logic        r_done;
    logic        r_f_found, r_f_blocked, r_f_woke, r_f_full;
    logic [2:0]  r_f_woken;
    logic signed [7:0] r_f_cnt;

    // process memory port signals
    logic           pm_we;
    logic [PAW-1:0] pm_waddr, pm_raddr;
    logic [31:0]    pm_wdata, pm_rdata;
    logic [7:0]     rd_tick, rd_prio;
    logic [15:0]    rd_slp;
    logic           rd_valid;
    logic [31:0]    rd_word;
    logic [PAW-1:0] r_rd_addr;
    logic           r_fwd;
    logic [31:0]    r_fwd_word;
    logic [52:0]    conv_prod;

    logic           qm_we;
    logic [QAW-1:0] qm_waddr, qm_raddr;
    logic [2:0]     qm_wdata, qm_rdata;

    sss_proc_mem #(.NUM_PROCS(NUM_PROCS)) u_pmem (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    sss_queue_mem #(.DEPTH(QDEPTH), .DW(3)) u_qmem (
        .i_clk(i_clk), .i_we(qm_we), .i_waddr(qm_waddr), .i_wdata(qm_wdata),
        .i_raddr(qm_raddr), .o_rdata(qm_rdata)
    );

    logic pid_ok, sid_ok;
    logic [SW-1:0] sidx;
    logic signed [7:0] cur_cnt, cnt_m1, cnt_p1;
    assign pid_ok  = 32'(r_pid) < NUM_PROCS;
    assign sid_ok  = 32'(r_sid) < NUM_SEMS;
    assign sidx    = SW'(r_sid);
    assign cur_cnt = r_cnt[sidx];
    assign cnt_m1  = cur_cnt - 8'sd1;
    assign cnt_p1  = cur_cnt + 8'sd1;

    // a write and a read of the same entry at one edge: take the written word
    assign rd_valid = r_valid[r_rd_addr];
    assign rd_word  = r_fwd ? r_fwd_word : (rd_valid ? pm_rdata : 32'd0);
    assign rd_tick  = rd_word[31:24];
    assign rd_prio  = rd_word[23:16];
    assign rd_slp   = rd_word[15:0];

    assign conv_prod = 53'(r_prod[25:0]) * 53'(MS_RECIP);

    assign o_busy      = (r_state != sss_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == sss_pkg::ST_IDLE) && !i_start;

    logic accept;
    assign accept = i_start && !o_busy;

    logic [PAW-1:0] idx_a;
    assign idx_a = r_idx[PAW-1:0];
    logic [QD-1:0] qpos;
    assign qpos = r_qi[QD-1:0];

    // V needs the negative count as queue length
    logic [7:0] neg_c;
    assign neg_c = 8'(-cur_cnt);

    always_comb begin
        n_state  = r_state;
        pm_we    = 1'b0;
        pm_waddr = r_pid[PAW-1:0];
        pm_wdata = {rd_tick, rd_prio, rd_slp};
        pm_raddr = r_pid[PAW-1:0];
        qm_we    = 1'b0;
        qm_waddr = {sidx, qpos};
        qm_wdata = r_pid;
        qm_raddr = {sidx, qpos};
        unique case (r_state)
            sss_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = sss_pkg::ST_RD;
                end
            end
            sss_pkg::ST_RD: begin
                pm_raddr = r_pid[PAW-1:0];
                n_state  = sss_pkg::ST_EXEC;
            end
            sss_pkg::ST_EXEC: begin
                n_state = sss_pkg::ST_DONE;
                priority case (r_op)
                    sss_pkg::OP_WRITE: begin
                        pm_we    = pid_ok;
                        pm_wdata = {r_tick, r_prio, r_slp};
                    end
                    sss_pkg::OP_SCHED: begin
                        pm_raddr = '0;
                        n_state  = sss_pkg::ST_SCAN;
                    end
                    sss_pkg::OP_SLEEP: begin
                        pm_we    = pid_ok;
                        pm_wdata = {rd_tick, rd_prio, r_conv};
                    end
                    sss_pkg::OP_P: begin
                        if (sid_ok && pid_ok && !(cnt_m1 < 0 && -32'(cnt_m1) > WAIT_DEPTH)
                            && cnt_m1 < 0) begin
                            pm_we    = 1'b1;
                            pm_wdata = {rd_tick, rd_prio, BLOCK_TICKS};
                            qm_we    = 1'b1;
                            qm_waddr = {sidx, QD'(-32'(cnt_m1) - 1)};
                            pm_raddr = '0;
                            n_state  = sss_pkg::ST_SCAN;
                        end
                    end
                    sss_pkg::OP_V: begin
                        if (sid_ok && cur_cnt < 8'sd127 && cnt_p1 <= 0) begin
                            qm_raddr = {sidx, QD'(0)};
                            n_state  = sss_pkg::ST_QRD;
                        end
                    end
                    default: ;
                endcase
            end
            sss_pkg::ST_SCAN: begin
                pm_raddr = PAW'(r_idx + PCW'(1));
                if (32'(r_idx) == NUM_PROCS - 1) begin
                    if (r_found || (rd_tick > r_best && rd_slp == 16'd0) || r_pass2) begin
                        n_state = sss_pkg::ST_DONE;
                    end else begin
                        pm_raddr = '0;
                        n_state  = sss_pkg::ST_RELOAD;
                    end
                end
            end
            sss_pkg::ST_RELOAD: begin
                pm_raddr = PAW'(r_idx + PCW'(1));
                pm_we    = 1'b1;
                pm_waddr = idx_a;
                pm_wdata = {rd_prio, rd_prio, rd_slp};
                if (32'(r_idx) == NUM_PROCS - 1) begin
                    pm_raddr = '0;
                    n_state  = sss_pkg::ST_SCAN;
                end
            end
            sss_pkg::ST_QRD: begin
                // r_qi==0: head read; later: slot qi read, write to qi-1
                if (r_qi == '0) begin
                    pm_raddr = qm_rdata[PAW-1:0];
                    qm_raddr = {sidx, QD'(1)};
                    n_state  = sss_pkg::ST_QSHIFT;
                end else begin
                    qm_we    = 1'b1;
                    qm_waddr = {sidx, QD'(r_qi - 1'b1)};
                    qm_wdata = qm_rdata;
                    qm_raddr = {sidx, QD'(r_qi + 1'b1)};
                    if (32'(r_qi) >= 32'(neg_c) || 32'(r_qi) + 1 >= WAIT_DEPTH) begin
                        n_state = sss_pkg::ST_DONE;
                    end else begin
                        n_state = sss_pkg::ST_QSHIFT;
                    end
                end
            end
            sss_pkg::ST_QSHIFT: begin
                if (r_qi == (QD+1)'(1)) begin
                    // clear sleep of woken process
                    pm_we    = 32'(r_f_woken) < NUM_PROCS;
                    pm_waddr = r_f_woken[PAW-1:0];
                    pm_wdata = {rd_tick, rd_prio, 16'd0};
                    if (neg_c == 8'd0 || WAIT_DEPTH == 1) begin
                        n_state = sss_pkg::ST_DONE;
                    end else begin
                        n_state = sss_pkg::ST_QRD;
                    end
                end else begin
                    qm_raddr = {sidx, qpos};
                    n_state  = sss_pkg::ST_QRD;
                end
            end
            sss_pkg::ST_DONE: begin
                n_state = sss_pkg::ST_IDLE;
            end
            default: n_state = sss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= pm_raddr;
        r_fwd      <= pm_we && (pm_waddr == pm_raddr);
        r_fwd_word <= pm_wdata;
        r_prod     <= 30'(i_sleep_millis) * 30'(TICK_HZ);
        if (accept) begin
            r_op   <= i_op;
            r_pid  <= i_proc_id;
            r_sid  <= i_sem_id;
            r_tick <= i_tick_budget;
            r_prio <= i_prio_level;
            r_slp  <= i_sleep_count;
        end
        if (r_state == sss_pkg::ST_RD) begin
            r_conv <= (r_prod >= SAT_PROD) ? 16'(sss_pkg::SLEEP_MAX) : conv_prod[51:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur   <= '0;
            r_done  <= 1'b0;
            for (int k = 0; k < NUM_SEMS; k++) begin
                r_cnt[k] <= '0;
            end
            r_idx <= '0; r_best <= '0; r_found <= 1'b0; r_pass2 <= 1'b0;
            r_qi <= '0;
            r_f_found <= 1'b0; r_f_blocked <= 1'b0; r_f_woke <= 1'b0;
            r_f_full <= 1'b0; r_f_woken <= '0; r_f_cnt <= '0;
        end else begin
            r_done <= (r_state == sss_pkg::ST_DONE);
            if (pm_we) begin
                r_valid[pm_waddr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready && 32'(i_cfg_index) < NUM_SEMS) begin
                r_cnt[SW'(i_cfg_index)] <= signed'({1'b0, i_cfg_data});
            end
            if (accept) begin
                r_f_found <= 1'b0; r_f_blocked <= 1'b0; r_f_woke <= 1'b0;
                r_f_full <= 1'b0; r_f_woken <= '0; r_f_cnt <= '0;
                r_idx <= '0; r_best <= '0; r_found <= 1'b0; r_pass2 <= 1'b0;
                r_qi <= '0;
            end
            if (r_state == sss_pkg::ST_EXEC) begin
                if (r_op == sss_pkg::OP_P && sid_ok) begin
                    if (!pid_ok) begin
                        r_f_cnt <= cur_cnt;
                    end else if (cnt_m1 < 0 && -32'(cnt_m1) > WAIT_DEPTH) begin
                        r_f_full <= 1'b1;
                        r_f_cnt  <= cur_cnt;
                    end else begin
                        r_cnt[sidx] <= cnt_m1;
                        r_f_cnt     <= cnt_m1;
                        r_f_blocked <= cnt_m1 < 0;
                    end
                end
                if (r_op == sss_pkg::OP_V && sid_ok) begin
                    if (cur_cnt >= 8'sd127) begin
                        r_f_full <= 1'b1;
                        r_f_cnt  <= cur_cnt;
                    end else begin
                        r_cnt[sidx] <= cnt_p1;
                        r_f_cnt     <= cnt_p1;
                        r_f_woke    <= cnt_p1 <= 0;
                    end
                end
            end
            if (r_state == sss_pkg::ST_SCAN) begin
                if (rd_tick > r_best && rd_slp == 16'd0) begin
                    r_best  <= rd_tick;
                    r_cur   <= 3'(idx_a);
                    r_found <= 1'b1;
                end
                if (32'(r_idx) == NUM_PROCS - 1) begin
                    r_idx     <= '0;
                    r_f_found <= r_found || (rd_tick > r_best && rd_slp == 16'd0);
                    r_pass2   <= 1'b1;
                end else begin
                    r_idx <= r_idx + PCW'(1);
                end
            end
            if (r_state == sss_pkg::ST_RELOAD) begin
                r_idx <= (32'(r_idx) == NUM_PROCS - 1) ? '0 : r_idx + PCW'(1);
            end
            if (r_state == sss_pkg::ST_QRD) begin
                if (r_qi == '0) begin
                    r_f_woken <= qm_rdata;
                end
                r_qi <= r_qi + 1'b1;
            end
        end
    end

    assign o_done          = r_done;
    assign o_ready_found   = r_f_found;
    assign o_ready_proc    = r_cur;
    assign o_blocked       = r_f_blocked;
    assign o_woke          = r_f_woke;
    assign o_woken_proc    = r_f_woken;
    assign o_sem_count_out = r_f_cnt;
    assign o_queue_full    = r_f_full;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy)) else $error("done without work");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("command not taken");
    a_block_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_blocked && o_woke)) else $error("blocked and woke");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for semaphore_sleep_scheduler: directed rows, then random commands.
// Depends on sss_pkg and the RTL top; predicts result words with its own process model, except typed rows.
module tb_top;
    import sss_pkg::*;

    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic              found;
        logic [2:0]        proc_id;
        logic              blocked;
        logic              woke;
        logic [2:0]        woken;
        logic signed [7:0] cnt;
        logic              full;
    } res_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  pid;
        logic [1:0]  sid;
        logic [7:0]  tick;
        logic [7:0]  prio;
        logic [15:0] scount;
        logic [19:0] millis;
        logic        typed;
        res_t        exp;
    } cmd_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic [2:0] i_op = '0;
    logic [2:0] i_proc_id = '0;
    logic [1:0] i_sem_id = '0;
    logic [7:0] i_tick_budget = '0;
    logic [7:0] i_prio_level = '0;
    logic [15:0] i_sleep_count = '0;
    logic [19:0] i_sleep_millis = '0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;
    logic o_busy, o_cfg_ready, o_done, o_ready_found, o_blocked, o_woke, o_queue_full;
    logic [2:0] o_ready_proc, o_woken_proc;
    logic signed [7:0] o_sem_count_out;

    semaphore_sleep_scheduler uut (.*);

    always #5 i_clk = ~i_clk;

    // process model
    logic [7:0]  tick_tbl [8];
    logic [7:0]  prio_tbl [8];
    logic [15:0] sleep_tbl [8];
    int          sem_val [4];
    logic [2:0]  waiters [4][8];
    logic [2:0]  running;

    res_t pending_words [$];
    int   errors = 0, cycles = 0, n_items = 0, n_words = 0;
    int   n_blocked = 0, n_woke = 0, n_full = 0, n_found = 0;

    function automatic logic [15:0] ms_to_ticks(logic [19:0] ms);
        longint t;
        t = longint'(ms) * TICK_HZ_D / MILLIS_SEC;
        return (t > SLEEP_MAX) ? 16'(SLEEP_MAX) : 16'(t);
    endfunction

    function automatic logic pick_runnable();
        int best;
        logic hit;
        best = 0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++)
            if (tick_tbl[i] > best && sleep_tbl[i] == 0) begin
                best = tick_tbl[i];
                running = 3'(i);
                hit = 1'b1;
            end
        return hit;
    endfunction

    function automatic logic reschedule();
        if (pick_runnable()) return 1'b1;
        for (int i = 0; i < 8; i++) tick_tbl[i] = prio_tbl[i];
        return pick_runnable();
    endfunction

    function automatic res_t apply_cmd(cmd_t c);
        res_t r;
        int   v;
        r = '0;
        case (c.op)
            OP_WRITE: begin
                tick_tbl[c.pid] = c.tick;
                prio_tbl[c.pid] = c.prio;
                sleep_tbl[c.pid] = c.scount;
            end
            OP_SCHED: r.found = reschedule();
            OP_SLEEP: sleep_tbl[c.pid] = ms_to_ticks(c.millis);
            OP_P: begin
                v = sem_val[c.sid];
                if (v - 1 < -WAIT_DEPTH_D) begin
                    r.full = 1'b1;
                end else begin
                    v = v - 1;
                    sem_val[c.sid] = v;
                    if (v < 0) begin
                        sleep_tbl[c.pid] = ms_to_ticks(20'(BLOCK_MILLIS));
                        waiters[c.sid][-v - 1] = c.pid;
                        r.blocked = 1'b1;
                        r.found = reschedule();
                    end
                end
                r.cnt = 8'(v);
            end
            OP_V: begin
                v = sem_val[c.sid];
                if (v >= COUNT_MAX) begin
                    r.full = 1'b1;
                end else begin
                    v = v + 1;
                    sem_val[c.sid] = v;
                    if (v <= 0) begin
                        sleep_tbl[waiters[c.sid][0]] = '0;
                        r.woke = 1'b1;
                        r.woken = waiters[c.sid][0];
                        for (int i = 0; i < -v && i + 1 < WAIT_DEPTH_D; i++)
                            waiters[c.sid][i] = waiters[c.sid][i + 1];
                    end
                end
                r.cnt = 8'(v);
            end
            default: ;
        endcase
        r.proc_id = running;
        return r;
    endfunction

    function automatic cmd_t row(logic [2:0] op, logic [2:0] pid, logic [1:0] sid,
                                 logic [7:0] tick, logic [7:0] prio, logic [15:0] sc,
                                 logic [19:0] ms, logic typed = 1'b0, res_t exp = '0);
        cmd_t c;
        c = '{op, pid, sid, tick, prio, sc, ms, typed, exp};
        return c;
    endfunction

    // issue one command word; leaves us on a falling edge
    task automatic issue(cmd_t c, int gap_pct);
        res_t r;
        i_start <= 1'b1;
        i_op <= c.op;
        i_proc_id <= c.pid;
        i_sem_id <= c.sid;
        i_tick_budget <= c.tick;
        i_prio_level <= c.prio;
        i_sleep_count <= c.scount;
        i_sleep_millis <= c.millis;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        r = apply_cmd(c);
        pending_words.push_back(c.typed ? c.exp : r);
        n_items++;
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic load_sems(int v0, int v1, int v2, int v3);
        int v [4];
        v = '{v0, v1, v2, v3};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data <= 7'(v[i]);
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            sem_val[i] = v[i];
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   pick;
        c = '0;
        pick = $urandom_range(99);
        c.pid = 3'($urandom_range(7));
        c.sid = 2'($urandom_range(3));
        c.tick = 8'($urandom);
        c.prio = 8'($urandom);
        c.scount = ($urandom_range(1)) ? 16'd0 : 16'($urandom);
        c.millis = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(200));
        if (pick < 15) c.op = OP_WRITE;
        else if (pick < 35) c.op = OP_SCHED;
        else if (pick < 45) c.op = OP_SLEEP;
        else if (pick < 70) c.op = OP_P;
        else if (pick < 95) c.op = OP_V;
        else c.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        return c;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d words outstanding", $time, pending_words.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_t e, a;
        if (i_rst_n && o_done === 1'b1) begin
            a = '{o_ready_found, o_ready_proc, o_blocked, o_woke, o_woken_proc,
                  o_sem_count_out, o_queue_full};
            n_words++;
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word %p", $time, a);
            end else begin
                e = pending_words.pop_front();
                if (a !== e) begin
                    errors++;
                    $display("%0t mismatch: exp found=%0b proc=%0d blk=%0b woke=%0b wkn=%0d cnt=%0d full=%0b",
                             $time, e.found, e.proc_id, e.blocked, e.woke, e.woken, e.cnt, e.full);
                    $display("%0t          act found=%0b proc=%0d blk=%0b woke=%0b wkn=%0d cnt=%0d full=%0b",
                             $time, a.found, a.proc_id, a.blocked, a.woke, a.woken, a.cnt, a.full);
                end
                n_found += e.found;
                n_blocked += e.blocked;
                n_woke += e.woke;
                n_full += e.full;
            end
        end
    end

    initial begin
        cmd_t  plan [$];
        res_t  full127;
        int    gap [3];
        foreach (tick_tbl[i]) begin
            tick_tbl[i] = '0;
            prio_tbl[i] = '0;
            sleep_tbl[i] = '0;
        end
        foreach (sem_val[i]) sem_val[i] = 0;
        running = '0;
        full127 = '0;
        full127.cnt = 8'sd127;
        full127.full = 1'b1;
        gap = '{38, 45, 0};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        load_sems(0, 0, 0, COUNT_MAX);

        plan.push_back(row(OP_SCHED, 0, 0, 0, 0, 0, 0, 1'b1, '0));
        plan.push_back(row(OP_UNDEF_LO, 7, 3, 8'hff, 8'hff, 16'hffff, 20'hfffff, 1'b1, '0));
        plan.push_back(row(OP_UNDEF_HI, 0, 0, 0, 0, 0, 0, 1'b1, '0));
        plan.push_back(row(OP_V, 0, 3, 0, 0, 0, 0, 1'b1, full127));
        plan.push_back(row(OP_WRITE, 0, 0, 8'hff, 8'hff, 16'h0000, 0));
        plan.push_back(row(OP_WRITE, 7, 0, 8'hff, 8'h01, 16'h0000, 0));
        plan.push_back(row(OP_WRITE, 3, 0, 8'h00, 8'hc8, 16'hffff, 0));
        plan.push_back(row(OP_SCHED, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(OP_SLEEP, 0, 0, 0, 0, 0, 20'hfffff));
        plan.push_back(row(OP_SLEEP, 7, 0, 0, 0, 0, 20'h00000));
        plan.push_back(row(OP_SCHED, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 9; i++)
            plan.push_back(row(OP_P, 3'(i), 0, 0, 0, 0, 0));
        plan.push_back(row(OP_V, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(OP_V, 0, 0, 0, 0, 0, 0));
        plan.push_back(row(OP_SCHED, 0, 0, 0, 0, 0, 0));
        foreach (plan[i]) issue(plan[i], 0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: load_sems(0, 1, 3, 2);
                1: load_sems(COUNT_MAX, 0, $urandom_range(COUNT_MAX), 1);
                default: load_sems(2, COUNT_MAX - 1, 0, 0);
            endcase
            for (int k = 0; k < 340; k++) begin
                issue(rand_cmd(), (ph == 2) ? 0 : gap[ph]);
                if (k == 170) drain();
            end
            drain();
        end

        $display("%0d commands, %0d result words: %0d scheduled, %0d blocked, %0d woken, %0d full",
                 n_items, n_words, n_found, n_blocked, n_woke, n_full);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/sss_pkg.sv
rtl/core/sss_proc_mem.sv
rtl/core/sss_queue_mem.sv
rtl/core/semaphore_sleep_scheduler.sv
dv/tb_top.sv
